[sv/hlpa_pkg.sv]
`timescale 1ns / 1ps

package hlpa_pkg;

   // default sizing of the vote table
   localparam int HLPA_MAX_ROWS   = 512;
   localparam int HLPA_MAX_COLS   = 512;
   localparam int HLPA_COUNT_BITS = 16;

   // bin indices never exceed 4095
   localparam int BIN_BITS = 12;

   // iteration counts of the shared units
   localparam int MUL_STEPS    = 5;
   localparam int CORDIC_STEPS = 16;
   localparam int SQRT_STEPS   = 26;
   localparam int DIV_STEPS    = 41;

   localparam logic signed [16:0] PI_Q12      = 17'sd12868;
   localparam logic signed [16:0] HALF_PI_Q12 = 17'sd6434;

   // register indices of the csr port
   localparam logic [2:0] CSR_MIN_DIST    = 3'd0;
   localparam logic [2:0] CSR_DIST_STEP   = 3'd1;
   localparam logic [2:0] CSR_MIN_THETA   = 3'd2;
   localparam logic [2:0] CSR_THETA_STEP  = 3'd3;
   localparam logic [2:0] CSR_ROWS_IN_USE = 3'd4;
   localparam logic [2:0] CSR_COLS_IN_USE = 3'd5;

   typedef enum logic [1:0] {
      FUNC_ADD      = 2'd0,
      FUNC_CLEAR    = 2'd1,
      FUNC_FIND_MAX = 2'd2
   } hlpa_func_type;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [15:0] first_x;
      logic signed [15:0] first_y;
      logic signed [15:0] second_x;
      logic signed [15:0] second_y;
   } hlpa_req_type;

   typedef struct packed {
      logic [15:0]        max_hits;
      logic signed [15:0] best_angle;
      logic signed [15:0] best_dist;
   } hlpa_rsp_type;

   // effective configuration handed to the geometry unit
   typedef struct packed {
      logic signed [15:0]  min_dist;
      logic [14:0]         dist_step;
      logic signed [15:0]  min_theta;
      logic [14:0]         theta_step;
      logic [BIN_BITS:0]   rows_eff;
      logic [BIN_BITS:0]   cols_eff;
   } hlpa_geom_cfg_type;

   typedef struct packed {
      logic                done;
      logic                hit;
      logic [BIN_BITS-1:0] row;
      logic [BIN_BITS-1:0] col;
   } hlpa_vote_type;

   typedef enum logic [3:0] {
      G_IDLE,
      G_PREP,
      G_MUL,
      G_CORDIC,
      G_SQRT,
      G_RDIV,
      G_BIN,
      G_ROWDIV,
      G_COLDIV,
      G_DONE
   } hlpa_geom_state_type;

   typedef enum logic [2:0] {
      T_CLEAR,
      T_IDLE,
      T_GEOM,
      T_VREAD,
      T_VWRITE,
      T_SCAN,
      T_DRAIN,
      T_FIN
   } hlpa_top_state_type;

   // arctangent of 2^-i in units of 2^-16 rad
   function automatic logic signed [18:0] hlpa_atan(input logic [3:0] idx);
      logic signed [18:0] val;
      case (idx)
         4'd0:    val = 19'sd51472;
         4'd1:    val = 19'sd30386;
         4'd2:    val = 19'sd16055;
         4'd3:    val = 19'sd8150;
         4'd4:    val = 19'sd4091;
         4'd5:    val = 19'sd2047;
         4'd6:    val = 19'sd1024;
         4'd7:    val = 19'sd512;
         4'd8:    val = 19'sd256;
         4'd9:    val = 19'sd128;
         4'd10:   val = 19'sd64;
         4'd11:   val = 19'sd32;
         4'd12:   val = 19'sd16;
         4'd13:   val = 19'sd8;
         4'd14:   val = 19'sd4;
         default: val = 19'sd2;
      endcase
      return val;
   endfunction

endpackage

[sv/hlpa_geom.sv]
`timescale 1ns / 1ps

module hlpa_geom (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  hlpa_pkg::hlpa_req_type    pts,
   input  hlpa_pkg::hlpa_geom_cfg_type cfg,
   output hlpa_pkg::hlpa_vote_type   vote
);
   import hlpa_pkg::*;

   hlpa_geom_state_type state_ff, state_in;
   logic [5:0]          step_ff, step_in;

   logic signed [15:0]  x1_ff, x1_in, y1_ff, y1_in;
   logic signed [16:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic signed [33:0]  prod_ff, prod_in, num_ff, num_in;
   logic [33:0]         sqsum_ff, sqsum_in;
   logic signed [19:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic signed [18:0]  z_ff, z_in;
   logic signed [16:0]  a_ff, a_in;
   logic [51:0]         sq_src_ff, sq_src_in;
   logic [27:0]         sq_rem_ff, sq_rem_in;
   logic [25:0]         sq_root_ff, sq_root_in;
   logic [40:0]         div_q_ff, div_q_in;
   logic [26:0]         div_rem_ff, div_rem_in;
   logic [25:0]         div_den_ff, div_den_in;
   logic                div_neg_ff, div_neg_in;
   logic [31:0]         r_ff, r_in;
   logic                row_ok_ff, row_ok_in;
   logic [BIN_BITS-1:0] row_ff, row_in, col_ff, col_in;
   logic                hit_ff, hit_in;

   // shared multiplier
   logic signed [16:0]  mul_a, mul_b;
   logic signed [33:0]  mul_p;
   // cordic step
   logic signed [19:0]  cx_sh, cy_sh, cx_nx, cy_nx;
   logic signed [18:0]  z_nx, z_rnd, cordic_tab;
   logic signed [16:0]  a_cordic;
   // root step
   logic [27:0]         sq_sh, sq_trial, sq_rem_nx;
   logic                sq_ge;
   logic [25:0]         sq_root_nx;
   // divider step
   logic [26:0]         div_sh, div_rem_nx;
   logic                div_ge;
   logic [40:0]         div_q_nx;
   logic                last_cordic, last_sqrt, last_div;
   // operands for the divider loads
   logic signed [33:0]  num_mag, rnum, rnum_mag;
   logic signed [17:0]  cnum, cnum_mag;
   logic signed [16:0]  ax, ay;

   always_comb begin
      case (step_ff[2:0])
         3'd0:    begin mul_a = dx_ff;        mul_b = dx_ff; end
         3'd1:    begin mul_a = dy_ff;        mul_b = dy_ff; end
         3'd2:    begin mul_a = 17'(x1_ff);   mul_b = dy_ff; end
         3'd3:    begin mul_a = 17'(y1_ff);   mul_b = dx_ff; end
         default: begin mul_a = dx_ff;        mul_b = dx_ff; end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      cx_sh      = cx_ff >>> step_ff[3:0];
      cy_sh      = cy_ff >>> step_ff[3:0];
      cordic_tab = hlpa_atan(step_ff[3:0]);
      if (cy_ff > 20'sd0) begin
         cx_nx = cx_ff + cy_sh;
         cy_nx = cy_ff - cx_sh;
         z_nx  = z_ff + cordic_tab;
      end else begin
         cx_nx = cx_ff - cy_sh;
         cy_nx = cy_ff + cx_sh;
         z_nx  = z_ff - cordic_tab;
      end
      z_rnd    = (z_nx + 19'sd8) >>> 4;
      a_cordic = 17'(z_rnd) - HALF_PI_Q12;
   end

   always_comb begin
      sq_sh      = {sq_rem_ff[25:0], sq_src_ff[51:50]};
      sq_trial   = {sq_root_ff, 2'b01};
      sq_ge      = sq_sh >= sq_trial;
      sq_rem_nx  = sq_ge ? sq_sh - sq_trial : sq_sh;
      sq_root_nx = {sq_root_ff[24:0], sq_ge};
   end

   always_comb begin
      div_sh     = {div_rem_ff[25:0], div_q_ff[40]};
      div_ge     = div_sh >= {1'b0, div_den_ff};
      div_rem_nx = div_ge ? div_sh - {1'b0, div_den_ff} : div_sh;
      div_q_nx   = {div_q_ff[39:0], div_ge};
   end

   assign last_cordic = step_ff == 6'(CORDIC_STEPS - 1);
   assign last_sqrt   = step_ff == 6'(SQRT_STEPS - 1);
   assign last_div    = step_ff == 6'(DIV_STEPS - 1);

   always_comb begin
      num_mag  = (num_ff < 34'sd0) ? -num_ff : num_ff;
      rnum     = $signed({2'b00, r_ff}) - 34'(cfg.min_dist);
      rnum_mag = (rnum < 34'sd0) ? -rnum : rnum;
      cnum     = 18'(a_ff) - 18'(cfg.min_theta);
      cnum_mag = (cnum < 18'sd0) ? -cnum : cnum;
      ax       = x1_ff[15] ? -17'(x1_ff) : 17'(x1_ff);
      ay       = y1_ff[15] ? -17'(y1_ff) : 17'(y1_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         G_IDLE:   if (start) state_in = G_PREP;
         G_PREP:   state_in = (dx_ff == 17'sd0 || dy_ff == 17'sd0) ? G_BIN : G_MUL;
         G_MUL:    if (step_ff == 6'(MUL_STEPS - 1)) state_in = G_CORDIC;
         G_CORDIC: if (last_cordic) state_in = G_SQRT;
         G_SQRT:   if (last_sqrt) state_in = G_RDIV;
         G_RDIV:   if (last_div) state_in = G_BIN;
         G_BIN:    state_in = G_ROWDIV;
         G_ROWDIV: if (last_div) state_in = G_COLDIV;
         G_COLDIV: if (last_div) state_in = G_DONE;
         G_DONE:   state_in = G_IDLE;
         default:  state_in = G_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      vote.done = state_ff == G_DONE;
      vote.hit  = hit_ff;
      vote.row  = row_ff;
      vote.col  = col_ff;
   end

   // datapath
   always_comb begin
      step_in    = step_ff + 6'd1;
      x1_in      = x1_ff;
      y1_in      = y1_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      prod_in    = prod_ff;
      num_in     = num_ff;
      sqsum_in   = sqsum_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      z_in       = z_ff;
      a_in       = a_ff;
      sq_src_in  = sq_src_ff;
      sq_rem_in  = sq_rem_ff;
      sq_root_in = sq_root_ff;
      div_q_in   = div_q_ff;
      div_rem_in = div_rem_ff;
      div_den_in = div_den_ff;
      div_neg_in = div_neg_ff;
      r_in       = r_ff;
      row_ok_in  = row_ok_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      hit_in     = hit_ff;
      case (state_ff)
         G_IDLE: begin
            step_in = '0;
            x1_in   = pts.first_x;
            y1_in   = pts.first_y;
            dx_in   = 17'(pts.second_x) - 17'(pts.first_x);
            dy_in   = 17'(pts.second_y) - 17'(pts.first_y);
         end
         G_PREP: begin
            step_in = '0;
            if (dx_ff == 17'sd0) begin
               r_in = 32'($unsigned(ax));
               a_in = x1_ff[15] ? PI_Q12 : 17'sd0;
            end else if (dy_ff == 17'sd0) begin
               r_in = 32'($unsigned(ay));
               a_in = y1_ff[15] ? HALF_PI_Q12 : -HALF_PI_Q12;
            end
            // vectoring needs x positive
            cx_in = dx_ff[16] ? -20'(dx_ff) : 20'(dx_ff);
            cy_in = dx_ff[16] ? -20'(dy_ff) : 20'(dy_ff);
            z_in  = '0;
         end
         G_MUL: begin
            prod_in = mul_p;
            case (step_ff[2:0])
               3'd1:    sqsum_in = 34'($unsigned(prod_ff));
               3'd2:    sqsum_in = sqsum_ff + 34'($unsigned(prod_ff));
               3'd3:    num_in   = prod_ff;
               3'd4:    num_in   = dx_ff[16] ? prod_ff - num_ff : num_ff - prod_ff;
               default: num_in   = num_ff;
            endcase
            if (step_ff == 6'(MUL_STEPS - 1)) step_in = '0;
         end
         G_CORDIC: begin
            cx_in = cx_nx;
            cy_in = cy_nx;
            z_in  = z_nx;
            if (last_cordic) begin
               step_in    = '0;
               a_in       = a_cordic;
               sq_src_in  = {2'b00, sqsum_ff, 16'd0};
               sq_rem_in  = '0;
               sq_root_in = '0;
            end
         end
         G_SQRT: begin
            sq_src_in  = sq_src_ff << 2;
            sq_rem_in  = sq_rem_nx;
            sq_root_in = sq_root_nx;
            if (last_sqrt) begin
               step_in    = '0;
               div_q_in   = {num_mag[32:0], 8'd0};
               div_rem_in = '0;
               div_den_in = sq_root_nx;
               div_neg_in = num_ff < 34'sd0;
            end
         end
         G_RDIV: begin
            div_q_in   = div_q_nx;
            div_rem_in = div_rem_nx;
            if (last_div) begin
               r_in = div_q_nx[31:0];
               // negative distance folds onto the opposite normal
               if (div_neg_ff && div_q_nx != '0) a_in = a_ff + PI_Q12;
            end
         end
         G_BIN: begin
            step_in    = '0;
            div_q_in   = {8'd0, rnum_mag[32:0]};
            div_rem_in = '0;
            div_den_in = {11'd0, cfg.dist_step};
            div_neg_in = rnum < 34'sd0;
         end
         G_ROWDIV: begin
            div_q_in   = div_q_nx;
            div_rem_in = div_rem_nx;
            if (last_div) begin
               step_in    = '0;
               row_ok_in  = (!div_neg_ff || div_q_nx == '0)
                            && (div_q_nx < 41'(cfg.rows_eff));
               row_in     = div_q_nx[BIN_BITS-1:0];
               div_q_in   = {24'd0, cnum_mag[16:0]};
               div_rem_in = '0;
               div_den_in = {11'd0, cfg.theta_step};
               div_neg_in = cnum < 18'sd0;
            end
         end
         G_COLDIV: begin
            div_q_in   = div_q_nx;
            div_rem_in = div_rem_nx;
            if (last_div) begin
               col_in = div_q_nx[BIN_BITS-1:0];
               hit_in = row_ok_ff && (!div_neg_ff || div_q_nx == '0)
                        && (div_q_nx < 41'(cfg.cols_eff));
            end
         end
         default: step_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff      <= x1_in;
      y1_ff      <= y1_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      prod_ff    <= prod_in;
      num_ff     <= num_in;
      sqsum_ff   <= sqsum_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      z_ff       <= z_in;
      a_ff       <= a_in;
      sq_src_ff  <= sq_src_in;
      sq_rem_ff  <= sq_rem_in;
      sq_root_ff <= sq_root_in;
      div_q_ff   <= div_q_in;
      div_rem_ff <= div_rem_in;
      div_den_ff <= div_den_in;
      div_neg_ff <= div_neg_in;
      r_ff       <= r_in;
      row_ok_ff  <= row_ok_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
      hit_ff     <= hit_in;
   end

endmodule

[sv/hough_line_pair_accumulator_unit.sv]
`timescale 1ns / 1ps
// Hough vote table of distance by angle, held in one synchronous RAM.
// Request channel (req_valid / req_stall / req_data): one transaction per
// item. func add-pair computes the normal form of the line through the two
// points and adds a saturating vote to its bin; clear zeroes the table;
// find-max scans the bins in use row-major and returns one transaction on
// the response channel (rsp_valid / rsp_stall / rsp_data). Unknown func
// codes are taken and dropped.
// An add-pair runs 16 CORDIC steps, 26 root steps and three 41-step
// divisions in one shared unit; horizontal or vertical lines skip to the
// two bin divisions. Find-max makes one RAM read a cycle over the bins in
// use; clear makes one RAM write a cycle over the whole table.
// Reset is synchronous; it starts the same clearing sweep, during which
// req_stall stays high (csr writes are taken throughout). The user must
// write the csr port only while the block is idle; the block does not
// enforce it. The response sits in an output register: a stalled response
// holds, and further items are accepted behind it; a second find-max waits
// at its end until the register is free.
module hough_line_pair_accumulator_unit #(
   parameter int MAX_ROWS   = hlpa_pkg::HLPA_MAX_ROWS,
   parameter int MAX_COLS   = hlpa_pkg::HLPA_MAX_COLS,
   parameter int COUNT_BITS = hlpa_pkg::HLPA_COUNT_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  hlpa_pkg::hlpa_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output hlpa_pkg::hlpa_rsp_type rsp_data,
   input  logic                   csr_wr_en,
   input  logic [2:0]             csr_index,
   input  logic [15:0]            csr_wdata
);
   import hlpa_pkg::*;

   localparam int DEPTH        = MAX_ROWS * MAX_COLS;
   localparam int ADDR_BITS    = $clog2(DEPTH);
   localparam int ROW_IDX_BITS = $clog2(MAX_ROWS);
   localparam int COL_IDX_BITS = $clog2(MAX_COLS);
   localparam int ROW_CNT_BITS = $clog2(MAX_ROWS + 1);
   localparam int COL_CNT_BITS = $clog2(MAX_COLS + 1);

   // csr registers
   logic signed [15:0] min_dist_ff, min_dist_in, min_theta_ff, min_theta_in;
   logic [14:0]        dist_step_ff, dist_step_in, theta_step_ff, theta_step_in;
   logic [9:0]         rows_ff, rows_in, cols_ff, cols_in;

   logic [14:0]             dstep_eff, tstep_eff;
   logic [ROW_CNT_BITS-1:0] rows_eff;
   logic [COL_CNT_BITS-1:0] cols_eff;

   hlpa_top_state_type state_ff, state_in;
   logic [ADDR_BITS-1:0]    addr_ff, addr_in, row_base_ff, row_base_in;
   logic [ROW_IDX_BITS-1:0] scan_row_ff, scan_row_in, pend_row_ff, pend_row_in;
   logic [COL_IDX_BITS-1:0] scan_col_ff, scan_col_in, pend_col_ff, pend_col_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [COUNT_BITS-1:0]   best_hits_ff, best_hits_in;
   logic [ROW_IDX_BITS-1:0] best_row_ff, best_row_in;
   logic [COL_IDX_BITS-1:0] best_col_ff, best_col_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   hlpa_rsp_type            rsp_data_ff, rsp_data_in;

   // vote RAM
   logic [COUNT_BITS-1:0] vote_mem [DEPTH];
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic                  mem_we;
   logic [ADDR_BITS-1:0]  mem_raddr;
   logic [COUNT_BITS-1:0] mem_wdata;

   logic                 req_take, geom_start, rsp_load, scan_last, scan_row_end;
   logic [ADDR_BITS-1:0] vote_addr;
   logic [31:0]          hits_wide;
   logic [15:0]          angle_off, dist_off;
   hlpa_geom_cfg_type    geom_cfg;
   hlpa_vote_type        vote;

   // effective configuration: zero steps act as one, counts clip to the table
   always_comb begin
      dstep_eff = (dist_step_ff == 15'd0) ? 15'd1 : dist_step_ff;
      tstep_eff = (theta_step_ff == 15'd0) ? 15'd1 : theta_step_ff;
      rows_eff  = (int'(rows_ff) > MAX_ROWS) ? ROW_CNT_BITS'(MAX_ROWS)
                                             : ROW_CNT_BITS'(rows_ff);
      cols_eff  = (int'(cols_ff) > MAX_COLS) ? COL_CNT_BITS'(MAX_COLS)
                                             : COL_CNT_BITS'(cols_ff);
      geom_cfg.min_dist   = min_dist_ff;
      geom_cfg.dist_step  = dstep_eff;
      geom_cfg.min_theta  = min_theta_ff;
      geom_cfg.theta_step = tstep_eff;
      geom_cfg.rows_eff   = (BIN_BITS + 1)'(rows_eff);
      geom_cfg.cols_eff   = (BIN_BITS + 1)'(cols_eff);
   end

   hlpa_geom u_geom (
      .clock (clock),
      .reset (reset),
      .start (geom_start),
      .pts   (req_data),
      .cfg   (geom_cfg),
      .vote  (vote)
   );

   assign vote_addr = ADDR_BITS'(ADDR_BITS'(vote.row[ROW_IDX_BITS-1:0])
                                 * ADDR_BITS'(MAX_COLS)
                                 + ADDR_BITS'(vote.col[COL_IDX_BITS-1:0]));

   assign scan_row_end = COL_CNT_BITS'(scan_col_ff) == cols_eff - COL_CNT_BITS'(1);
   assign scan_last    = scan_row_end
                         && (ROW_CNT_BITS'(scan_row_ff) == rows_eff - ROW_CNT_BITS'(1));
   assign req_take     = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         T_CLEAR: if (addr_ff == ADDR_BITS'(DEPTH - 1)) state_in = T_IDLE;
         T_IDLE: begin
            if (req_take) begin
               if (req_data.func == FUNC_ADD) begin
                  state_in = T_GEOM;
               end else if (req_data.func == FUNC_CLEAR) begin
                  state_in = T_CLEAR;
               end else if (req_data.func == FUNC_FIND_MAX) begin
                  state_in = (rows_eff == '0 || cols_eff == '0) ? T_FIN : T_SCAN;
               end
            end
         end
         T_GEOM:   if (vote.done) state_in = vote.hit ? T_VREAD : T_IDLE;
         T_VREAD:  state_in = T_VWRITE;
         T_VWRITE: state_in = T_IDLE;
         T_SCAN:   if (scan_last) state_in = T_DRAIN;
         T_DRAIN:  state_in = T_FIN;
         T_FIN:    if (!rsp_valid_ff || !rsp_stall) state_in = T_IDLE;
         default:  state_in = T_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall  = state_ff != T_IDLE;
      geom_start = state_ff == T_IDLE && req_valid && req_data.func == FUNC_ADD;
      rsp_load   = state_ff == T_FIN && (!rsp_valid_ff || !rsp_stall);
      mem_we     = state_ff == T_CLEAR || state_ff == T_VWRITE;
      mem_raddr  = (state_ff == T_SCAN) ? row_base_ff + ADDR_BITS'(scan_col_ff) : addr_ff;
      if (state_ff == T_VWRITE && rd_data_ff != '1) begin
         mem_wdata = rd_data_ff + COUNT_BITS'(1);
      end else if (state_ff == T_VWRITE) begin
         mem_wdata = rd_data_ff;
      end else begin
         mem_wdata = '0;
      end
   end

   // csr writes
   always_comb begin
      min_dist_in   = min_dist_ff;
      dist_step_in  = dist_step_ff;
      min_theta_in  = min_theta_ff;
      theta_step_in = theta_step_ff;
      rows_in       = rows_ff;
      cols_in       = cols_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MIN_DIST:    min_dist_in   = csr_wdata;
            CSR_DIST_STEP:   dist_step_in  = csr_wdata[14:0];
            CSR_MIN_THETA:   min_theta_in  = csr_wdata;
            CSR_THETA_STEP:  theta_step_in = csr_wdata[14:0];
            CSR_ROWS_IN_USE: rows_in       = csr_wdata[9:0];
            CSR_COLS_IN_USE: cols_in       = csr_wdata[9:0];
            default:         rows_in       = rows_ff;
         endcase
      end
   end

   // scan and response datapath
   always_comb begin
      addr_in       = addr_ff;
      row_base_in   = row_base_ff;
      scan_row_in   = scan_row_ff;
      scan_col_in   = scan_col_ff;
      pend_valid_in = 1'b0;
      pend_row_in   = scan_row_ff;
      pend_col_in   = scan_col_ff;
      best_hits_in  = best_hits_ff;
      best_row_in   = best_row_ff;
      best_col_in   = best_col_ff;

      case (state_ff)
         T_CLEAR: addr_in = addr_ff + ADDR_BITS'(1);
         T_IDLE: begin
            addr_in      = '0;
            row_base_in  = '0;
            scan_row_in  = '0;
            scan_col_in  = '0;
            best_hits_in = '0;
            best_row_in  = '0;
            best_col_in  = '0;
         end
         T_GEOM: addr_in = vote_addr;
         T_SCAN: begin
            pend_valid_in = 1'b1;
            if (scan_row_end) begin
               scan_col_in = '0;
               scan_row_in = scan_row_ff + ROW_IDX_BITS'(1);
               row_base_in = row_base_ff + ADDR_BITS'(MAX_COLS);
            end else begin
               scan_col_in = scan_col_ff + COL_IDX_BITS'(1);
            end
         end
         default: addr_in = addr_ff;
      endcase

      // read data lands in the cycle after its address; strict compare keeps the first
      if (pend_valid_ff && rd_data_ff > best_hits_ff) begin
         best_hits_in = rd_data_ff;
         best_row_in  = pend_row_ff;
         best_col_in  = pend_col_ff;
      end
   end

   always_comb begin
      hits_wide    = 32'(best_hits_ff);
      angle_off    = 16'(best_col_ff) * 16'(tstep_eff);
      dist_off     = 16'(best_row_ff) * 16'(dstep_eff);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (best_hits_ff == '0) begin
            rsp_data_in = '0;
         end else begin
            rsp_data_in.max_hits   = (hits_wide > 32'd65535) ? 16'hFFFF : hits_wide[15:0];
            rsp_data_in.best_angle = min_theta_ff + angle_off;
            rsp_data_in.best_dist  = min_dist_ff + dist_off;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= T_CLEAR;
         addr_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         min_dist_ff   <= 16'sd0;
         dist_step_ff  <= 15'd41;
         min_theta_ff  <= -16'sd12868;
         theta_step_ff <= 15'd71;
         rows_ff       <= 10'd512;
         cols_ff       <= 10'd361;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         min_dist_ff   <= min_dist_in;
         dist_step_ff  <= dist_step_in;
         min_theta_ff  <= min_theta_in;
         theta_step_ff <= theta_step_in;
         rows_ff       <= rows_in;
         cols_ff       <= cols_in;
      end
   end

   always_ff @(posedge clock) begin
      row_base_ff  <= row_base_in;
      scan_row_ff  <= scan_row_in;
      scan_col_ff  <= scan_col_in;
      pend_row_ff  <= pend_row_in;
      pend_col_ff  <= pend_col_in;
      best_hits_ff <= best_hits_in;
      best_row_ff  <= best_row_in;
      best_col_ff  <= best_col_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) vote_mem[addr_ff] <= mem_wdata;
      rd_data_ff <= vote_mem[mem_raddr];
   end

endmodule

[sv/hlpa_checker.sv]
`timescale 1ns / 1ps

module hlpa_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input hlpa_pkg::hlpa_req_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input hlpa_pkg::hlpa_rsp_type rsp_data
);
   import hlpa_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // reset starts the clearing sweep
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> req_stall)
      else $error("request taken straight after reset");

   // an empty table reports no bin
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.max_hits == 16'd0
      |-> rsp_data.best_angle == 16'sd0 && rsp_data.best_dist == 16'sd0)
      else $error("empty result with nonzero bin");

   // clear and add both occupy the block after acceptance
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall
      && (req_data.func == FUNC_CLEAR || req_data.func == FUNC_ADD)
      |=> req_stall)
      else $error("block idle right after clear or add");

endmodule

bind hough_line_pair_accumulator_unit hlpa_checker u_hlpa_checker (.*);

[tb/tb_hough_line_pair_accumulator_unit.sv]
`timescale 1ns / 1ps

module tb_hough_line_pair_accumulator_unit;
   import hlpa_pkg::*;

   localparam int TAB_ROWS = HLPA_MAX_ROWS;
   localparam int TAB_COLS = HLPA_MAX_COLS;
   localparam int LONG_HOLD = 3000;     // cycles of forced response back-pressure
   localparam int ADD_SETTLE = 250;     // settle time after an add, which returns no response
   localparam int CLEAR_SETTLE = TAB_ROWS * TAB_COLS + 200;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   hlpa_req_type  req_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b1;
   hlpa_rsp_type  rsp_data;
   logic          csr_wr_en = 1'b0;
   logic [2:0]    csr_index = '0;
   logic [15:0]   csr_wdata = '0;

   hough_line_pair_accumulator_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #40_000_000;
      $display("timeout at %0t", $time);
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Vote-table mirror and its configuration
   // ---------------------------------------------------------------------
   logic [15:0]   votes [0:TAB_ROWS*TAB_COLS-1];
   longint        m_min_dist, m_min_theta;
   int unsigned   m_dist_step, m_theta_step, m_rows, m_cols;

   hlpa_rsp_type  peak_q [$];           // find-max answers still owed by the block
   int            errors = 0;
   int            n_items = 0;
   int            n_peaks = 0;
   int            settle = 0;           // quiet cycles needed after the last transaction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // vectoring rotation, angle in 2^-16 rad, x positive
   function automatic longint atan_vec(longint x, longint y);
      longint z, xs, ys;
      longint steps [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2};
      z = 0;
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; z += steps[i];
         end else begin
            x -= ys; y += xs; z -= steps[i];
         end
      end
      return z;
   endfunction

   function automatic longint rows_lim();
      return (m_rows > TAB_ROWS) ? TAB_ROWS : m_rows;
   endfunction

   function automatic longint cols_lim();
      return (m_cols > TAB_COLS) ? TAB_COLS : m_cols;
   endfunction

   function automatic longint dstep_use();
      return (m_dist_step == 0) ? 1 : m_dist_step;
   endfunction

   function automatic longint tstep_use();
      return (m_theta_step == 0) ? 1 : m_theta_step;
   endfunction

   function automatic void cast_vote(hlpa_req_type it);
      longint x1, y1, dx, dy, r, a, row, col, cx, cy, num;
      longint unsigned len;
      int idx;
      x1 = it.first_x;
      y1 = it.first_y;
      dx = longint'(it.second_x) - x1;
      dy = longint'(it.second_y) - y1;
      if (dx == 0) begin
         if (x1 < 0) begin r = -x1; a = PI_Q12; end
         else begin r = x1; a = 0; end
      end else if (dy == 0) begin
         if (y1 < 0) begin r = -y1; a = HALF_PI_Q12; end
         else begin r = y1; a = -HALF_PI_Q12; end
      end else begin
         cx = dx; cy = dy;
         if (cx < 0) begin cx = -cx; cy = -cy; end
         a = ((atan_vec(cx, cy) + 8) >>> 4) - HALF_PI_Q12;
         len = root_floor(longint'(dx * dx + dy * dy) << 16);
         num = x1 * dy - y1 * dx;
         if (dx < 0) num = -num;
         r = (num * 256) / longint'(len);
         if (r < 0) begin r = -r; a += PI_Q12; end
      end
      row = (r - m_min_dist) / dstep_use();
      col = (a - m_min_theta) / tstep_use();
      if (row < 0 || row >= rows_lim() || col < 0 || col >= cols_lim()) return;
      idx = int'(row) * TAB_COLS + int'(col);
      if (votes[idx] != 16'hFFFF) votes[idx] = votes[idx] + 1;
   endfunction

   function automatic hlpa_rsp_type scan_peak();
      hlpa_rsp_type res;
      int br, bc;
      logic [15:0] hits;
      hits = 0; br = 0; bc = 0;
      for (int rr = 0; rr < rows_lim(); rr++)
         for (int cc = 0; cc < cols_lim(); cc++)
            if (votes[rr*TAB_COLS+cc] > hits) begin
               hits = votes[rr*TAB_COLS+cc]; br = rr; bc = cc;
            end
      res = '0;
      if (hits != 0) begin
         res.max_hits = hits;
         res.best_angle = 16'(m_min_theta + bc * tstep_use());
         res.best_dist = 16'(m_min_dist + br * dstep_use());
      end
      return res;
   endfunction

   // apply one accepted transaction to the mirror; returns 1 with a find-max
   function automatic bit predict_item(hlpa_req_type it, output hlpa_rsp_type peak);
      peak = '0;
      case (it.func)
         FUNC_ADD: begin
            cast_vote(it);
            settle = ADD_SETTLE;
         end
         FUNC_CLEAR: begin
            foreach (votes[i]) votes[i] = '0;
            settle = CLEAR_SETTLE;
         end
         FUNC_FIND_MAX: begin
            peak = scan_peak();
            settle = 10;
            return 1'b1;
         end
         default: settle = 10;
      endcase
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   int burst_left = 0;

   task automatic offer(hlpa_req_type it, bit typed, hlpa_rsp_type typed_rsp);
      hlpa_rsp_type peak;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      n_items++;
      if (predict_item(it, peak)) peak_q.push_back(typed ? typed_rsp : peak);
   endtask

   task automatic go_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (peak_q.size() == 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_MIN_DIST:    m_min_dist = longint'($signed(val));
         CSR_DIST_STEP:   m_dist_step = val[14:0];
         CSR_MIN_THETA:   m_min_theta = longint'($signed(val));
         CSR_THETA_STEP:  m_theta_step = val[14:0];
         CSR_ROWS_IN_USE: m_rows = val[9:0];
         CSR_COLS_IN_USE: m_cols = val[9:0];
         default: ;
      endcase
   endtask

   task automatic set_all(logic [15:0] md, logic [15:0] ds, logic [15:0] mt,
                          logic [15:0] ts, logic [15:0] nr, logic [15:0] nc);
      write_reg(CSR_MIN_DIST, md);
      write_reg(CSR_DIST_STEP, ds);
      write_reg(CSR_MIN_THETA, mt);
      write_reg(CSR_THETA_STEP, ts);
      write_reg(CSR_ROWS_IN_USE, nr);
      write_reg(CSR_COLS_IN_USE, nc);
      csr_wr_en <= 1'b0;
   endtask

   function automatic hlpa_req_type mk(hlpa_func_type f, int x1, int y1, int x2, int y2);
      hlpa_req_type it;
      it.func = f;
      it.first_x = 16'(x1);
      it.first_y = 16'(y1);
      it.second_x = 16'(x2);
      it.second_y = 16'(y2);
      return it;
   endfunction

   // mostly well-formed add pairs, some axis-aligned, some find-max and junk codes
   function automatic hlpa_req_type random_item(int span);
      hlpa_req_type it;
      int pick;
      pick = $urandom_range(0, 99);
      it = '0;
      it.first_x = 16'($urandom_range(0, 2*span) - span);
      it.first_y = 16'($urandom_range(0, 2*span) - span);
      it.second_x = 16'($urandom_range(0, 2*span) - span);
      it.second_y = 16'($urandom_range(0, 2*span) - span);
      if (pick < 5) begin
         it.first_x = 16'($urandom); it.first_y = 16'($urandom);
         it.second_x = 16'($urandom); it.second_y = 16'($urandom);
         it.func = 2'd3;
      end else if (pick < 15) begin
         it.func = FUNC_FIND_MAX;
      end else begin
         it.func = FUNC_ADD;
         if (pick < 22) it.second_x = it.first_x;
         else if (pick < 29) it.second_y = it.first_y;
         else if (pick < 34) begin
            it.first_x = 16'($urandom); it.first_y = 16'($urandom);
            it.second_x = 16'($urandom); it.second_y = 16'($urandom);
         end
      end
      return it;
   endfunction

   // directed rows: item, whether the answer is typed in, and that answer
   typedef struct {
      hlpa_req_type item;
      bit           typed;
      hlpa_rsp_type answer;
   } stim_row_type;

   stim_row_type directed [$];

   task automatic add_row(hlpa_req_type it, bit typed = 0, hlpa_rsp_type ans = '0);
      stim_row_type row;
      row.item = it; row.typed = typed; row.answer = ans;
      directed.push_back(row);
   endtask

   initial begin
      hlpa_rsp_type none;
      hlpa_req_type junk;
      none = '0;
      foreach (votes[i]) votes[i] = '0;
      m_min_dist = 0; m_dist_step = 41; m_min_theta = -12868; m_theta_step = 71;
      m_rows = 512; m_cols = 361;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset values kept except for a two-row table: cheap scans, r below 82
      write_reg(CSR_ROWS_IN_USE, 16'd2);
      csr_wr_en <= 1'b0;

      add_row(mk(FUNC_FIND_MAX, 0, 0, 0, 0), 1, none);         // empty after reset
      add_row(mk(FUNC_ADD, 10, -100, 10, 300));                 // vertical, x positive
      add_row(mk(FUNC_ADD, -20, 7, -20, -9));                   // vertical, x negative
      add_row(mk(FUNC_ADD, 400, -30, -800, -30));               // horizontal, y negative
      add_row(mk(FUNC_ADD, -5, 50, 900, 50));                   // horizontal, y positive
      add_row(mk(FUNC_ADD, 5, 5, 5, 5));                        // both points equal
      add_row(mk(FUNC_ADD, 0, 0, 4096, 4096));
      add_row(mk(FUNC_ADD, -4096, 4096, 4096, -4096));
      add_row(mk(FUNC_ADD, 4096, 0, 0, 4096));                  // dx negative
      add_row(mk(FUNC_ADD, 30, 1, -8000, -2));                  // shallow, r negative side
      add_row(mk(FUNC_ADD, -32768, -32768, 32767, 32767));
      add_row(mk(FUNC_ADD, 32767, -32768, -32768, 32767));
      add_row(mk(FUNC_ADD, 32767, 32767, -32768, -32768));
      add_row(mk(FUNC_ADD, -32768, 32767, -32768, -32768));
      junk = mk(FUNC_ADD, -1, -1, -1, -1);
      junk.func = 2'd3;                                         // unknown code: dropped
      add_row(junk);
      add_row(mk(FUNC_FIND_MAX, 0, 0, 0, 0));
      add_row(mk(FUNC_CLEAR, 0, 0, 0, 0));
      add_row(mk(FUNC_FIND_MAX, 0, 0, 0, 0), 1, none);         // empty after clear
      add_row(mk(FUNC_ADD, 0, -32768, 0, 32767));               // r zero, angle zero
      add_row(mk(FUNC_ADD, 0, 12, 0, 12));
      add_row(mk(FUNC_FIND_MAX, 0, 0, 0, 0));

      foreach (directed[i]) offer(directed[i].item, directed[i].typed, directed[i].answer);
      go_quiet();

      // coarse bins over the whole plane
      set_all(16'd0, 16'd4096, -16'sd12868, 16'd1608, 16'd16, 16'd17);
      repeat (400) offer(random_item(32767), 0, none);
      go_quiet();

      // extreme origins and steps, two by two bins
      set_all(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd2, 16'd2);
      repeat (400) offer(random_item(32767), 0, none);
      go_quiet();

      // zero steps stand for one; single angle column at zero, fine distance rows
      set_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd512, 16'd1);
      repeat (400) offer(random_item(600), 0, none);
      go_quiet();

      // no columns at all with an oversized row count clamped, then one row
      set_all(16'd0, 16'd4096, -16'sd12868, 16'd50, 16'd1023, 16'd0);
      repeat (40) offer(random_item(32767), 0, none);
      go_quiet();
      set_all(16'hF000, 16'd20000, -16'sd12868, 16'd50, 16'd1, 16'd512);
      repeat (360) offer(random_item(32767), 0, none);

      req_valid <= 1'b0;
      @(posedge clock);
      wait (peak_q.size() == 0);
      repeat (300) @(posedge clock);
      $display("%0d request transactions over six register settings, %0d find-max answers checked",
               n_items, n_peaks);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", errors);
         $display("status: fail");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Response side: own stall pattern, one long hold-off after a few answers
   // ---------------------------------------------------------------------
   int hold_left = 0;
   int mode_left = 0;
   int stall_pct = 0;
   bit held = 0;

   always @(posedge clock) begin
      if (mode_left == 0) begin
         mode_left <= $urandom_range(16, 128);
         stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
      end else begin
         mode_left <= mode_left - 1;
      end
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!held && n_peaks == 5) begin
         held <= 1'b1;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (peak_q.size() == 0) begin
            $display("%0t: unexpected response %p", $time, rsp_data);
            errors++;
         end else begin
            if (rsp_data.max_hits !== peak_q[0].max_hits) begin
               $display("%0t: max_hits expected %0d actual %0d", $time,
                        peak_q[0].max_hits, rsp_data.max_hits);
               errors++;
            end
            if (rsp_data.best_angle !== peak_q[0].best_angle) begin
               $display("%0t: best_angle expected %0d actual %0d", $time,
                        peak_q[0].best_angle, rsp_data.best_angle);
               errors++;
            end
            if (rsp_data.best_dist !== peak_q[0].best_dist) begin
               $display("%0t: best_dist expected %0d actual %0d", $time,
                        peak_q[0].best_dist, rsp_data.best_dist);
               errors++;
            end
            void'(peak_q.pop_front());
            n_peaks++;
         end
      end
   end

endmodule

[hough_line_pair_accumulator_unit.f]
sv/hlpa_pkg.sv
sv/hlpa_geom.sv
sv/hough_line_pair_accumulator_unit.sv
sv/hlpa_checker.sv
tb/tb_hough_line_pair_accumulator_unit.sv
